// File: rtl/dfia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfia_pkg
// Shared types and constants for the deferred-free index allocator.
// ----------------------------------------------------------------------------
package dfia_pkg;

  localparam int unsigned IDX_W         = 10;
  localparam int unsigned CFG_W         = 11;
  localparam int unsigned MAX_SLOTS_DEF = 1024;

  typedef enum logic [1:0] {
    CMD_ALLOC_ANY   = 2'd0,
    CMD_ALLOC_GIVEN = 2'd1,
    CMD_FREE        = 2'd2,
    CMD_FLUSH       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_MISSING  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    status_e          status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_cfg;
    logic accept;
    logic pop_issue;
    logic pop_finish;
    logic empty_fail;
    logic free_do;
    logic scan_start;
    logic scan_run;
    logic scan_fail;
    logic shift_start;
    logic shift_run;
    logic shift_finish;
    logic flush_start;
    logic flush_run;
    logic flush_finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_blocked;
    logic avail_empty;
    logic scan_hit;
    logic stk_drain;
    logic def_drain;
  } stat_t;

endpackage

// File: rtl/dfia_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfia_ctrl
// Command sequencer: accepts requests and steps the datapath through pop,
// searched allocation with compaction, deferred push and flush.
// ----------------------------------------------------------------------------
module dfia_ctrl
  import dfia_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  cmd_e  in_cmd_i,
  output logic  in_stall_o,
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   idle;
  logic   accept;

  assign idle        = (state_q == S_IDLE);
  assign in_stall_o  = !idle || stat_i.out_blocked;
  assign cfg_ready_o = idle;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    ctl_o          = '0;
    state_d        = state_q;
    ctl_o.load_cfg = cfg_valid_i && cfg_ready_o;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.accept = 1'b1;
          case (in_cmd_i)
            CMD_ALLOC_ANY: begin
              if (stat_i.avail_empty) begin
                ctl_o.empty_fail = 1'b1;
              end else begin
                ctl_o.pop_issue = 1'b1;
                state_d         = S_POP;
              end
            end
            CMD_ALLOC_GIVEN: begin
              ctl_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
            CMD_FREE: begin
              ctl_o.free_do = 1'b1;
            end
            default: begin
              ctl_o.flush_start = 1'b1;
              state_d           = S_FLUSH;
            end
          endcase
        end
      end
      S_POP: begin
        ctl_o.pop_finish = 1'b1;
        state_d          = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          ctl_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end else if (stat_i.stk_drain) begin
          ctl_o.scan_fail = 1'b1;
          state_d         = S_IDLE;
        end else begin
          ctl_o.scan_run = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat_i.stk_drain) begin
          ctl_o.shift_finish = 1'b1;
          state_d            = S_IDLE;
        end else begin
          ctl_o.shift_run = 1'b1;
        end
      end
      S_FLUSH: begin
        if (stat_i.def_drain) begin
          ctl_o.flush_finish = 1'b1;
          state_d            = S_IDLE;
        end else begin
          ctl_o.flush_run = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/dfia_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfia_dpath
// Available stack and deferred list memories, counters, scan pointer and
// the result register.
// ----------------------------------------------------------------------------
module dfia_dpath
  import dfia_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  req_t             in_req_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  ctl_t             ctl_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned EW = (AW > IDX_W) ? AW : IDX_W;

  logic [EW-1:0]    stk_mem [MAX_SLOTS];
  logic [IDX_W-1:0] def_mem [MAX_SLOTS];

  logic [CW-1:0] loaded_n_q, loaded_n_d;
  logic [CW-1:0] avail_q, avail_d;
  logic [CW-1:0] clean_q, clean_d;
  logic [CW-1:0] def_cnt_q, def_cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] rd_pos_q, rd_pos_d;
  logic [CW-1:0] hit_q, hit_d;
  logic          rd_vld_q, rd_vld_d;
  logic          ovf_q, ovf_d;
  req_t          req_q, req_d;
  logic          out_vld_q, out_vld_d;
  rsp_t          out_rsp_q, out_rsp_d;

  logic [EW-1:0]    stk_rdata_q;
  logic [IDX_W-1:0] def_rdata_q;
  logic             stk_re, stk_we, def_re, def_we;
  logic [AW-1:0]    stk_raddr, stk_waddr, def_raddr;
  logic [EW-1:0]    stk_wdata;

  logic [CW-1:0] avail_m1;
  logic [CW-1:0] imp_cnt;
  logic [CW-1:0] cfg_n;
  logic [EW-1:0] stk_val;
  logic [EW-1:0] want;
  logic          res_load;
  rsp_t          res;

  // Entries below the clean mark were never rewritten since the last reload
  // and hold their reload value implicitly.
  assign imp_cnt  = loaded_n_q - CW'(1) - rd_pos_q;
  assign stk_val  = (rd_pos_q < clean_q) ? EW'(imp_cnt[AW-1:0]) : stk_rdata_q;
  assign want     = EW'(req_q.index);
  assign avail_m1 = avail_q - CW'(1);
  assign cfg_n    = (32'(cfg_data_i) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(cfg_data_i);

  assign stat_o.out_blocked = out_vld_q && out_stall_i;
  assign stat_o.avail_empty = (avail_q == '0);
  assign stat_o.scan_hit    = rd_vld_q && (stk_val == want);
  assign stat_o.stk_drain   = (ptr_q == avail_q) && !rd_vld_q;
  assign stat_o.def_drain   = (ptr_q == def_cnt_q) && !rd_vld_q;

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    loaded_n_d = loaded_n_q;
    avail_d    = avail_q;
    clean_d    = clean_q;
    def_cnt_d  = def_cnt_q;
    ptr_d      = ptr_q;
    rd_pos_d   = rd_pos_q;
    hit_d      = hit_q;
    rd_vld_d   = rd_vld_q;
    ovf_d      = ovf_q;
    req_d      = req_q;
    stk_re     = 1'b0;
    stk_raddr  = ptr_q[AW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = avail_q[AW-1:0];
    stk_wdata  = EW'(def_rdata_q);
    def_re     = 1'b0;
    def_raddr  = ptr_q[AW-1:0];
    def_we     = 1'b0;
    res_load   = 1'b0;
    res        = '{granted_index: '0, status: ST_OK};

    if (ctl_i.load_cfg) begin
      loaded_n_d = cfg_n;
      avail_d    = cfg_n;
      clean_d    = cfg_n;
    end

    if (ctl_i.accept) begin
      req_d = in_req_i;
    end

    if (ctl_i.pop_issue) begin
      stk_re    = 1'b1;
      stk_raddr = avail_m1[AW-1:0];
      rd_pos_d  = avail_m1;
    end

    if (ctl_i.pop_finish) begin
      avail_d            = avail_m1;
      clean_d            = (clean_q > avail_m1) ? avail_m1 : clean_q;
      res_load           = 1'b1;
      res.granted_index  = stk_val[IDX_W-1:0];
    end

    if (ctl_i.empty_fail) begin
      res_load   = 1'b1;
      res.status = ST_EMPTY;
    end

    if (ctl_i.free_do) begin
      res_load          = 1'b1;
      res.granted_index = in_req_i.index;
      if (def_cnt_q < CW'(MAX_SLOTS)) begin
        def_we    = 1'b1;
        def_cnt_d = def_cnt_q + CW'(1);
      end else begin
        res.status = ST_OVERFLOW;
      end
    end

    if (ctl_i.scan_start || ctl_i.flush_start) begin
      ptr_d    = '0;
      rd_vld_d = 1'b0;
      ovf_d    = 1'b0;
    end

    // Stream the stack one entry per cycle; compare or move each entry in the cycle after its read.
    if (ctl_i.scan_run || ctl_i.shift_run) begin
      if (ptr_q < avail_q) begin
        stk_re    = 1'b1;
        stk_raddr = ptr_q[AW-1:0];
        rd_pos_d  = ptr_q;
        rd_vld_d  = 1'b1;
        ptr_d     = ptr_q + CW'(1);
      end else begin
        rd_vld_d = 1'b0;
      end
    end

    // Compact: each entry above the hit moves down by one.
    if (ctl_i.shift_run && rd_vld_q) begin
      stk_we    = 1'b1;
      stk_waddr = rd_pos_q[AW-1:0] - AW'(1);
      stk_wdata = stk_val;
    end

    if (ctl_i.shift_start) begin
      hit_d    = rd_pos_q;
      ptr_d    = rd_pos_q + CW'(1);
      rd_vld_d = 1'b0;
    end

    if (ctl_i.scan_fail) begin
      res_load   = 1'b1;
      res.status = ST_MISSING;
    end

    if (ctl_i.shift_finish) begin
      avail_d           = avail_m1;
      clean_d           = (clean_q > hit_q) ? hit_q : clean_q;
      res_load          = 1'b1;
      res.granted_index = req_q.index;
    end

    if (ctl_i.flush_run) begin
      if (ptr_q < def_cnt_q) begin
        def_re    = 1'b1;
        def_raddr = ptr_q[AW-1:0];
        rd_vld_d  = 1'b1;
        ptr_d     = ptr_q + CW'(1);
      end else begin
        rd_vld_d = 1'b0;
      end
      if (rd_vld_q) begin
        if (avail_q < CW'(MAX_SLOTS)) begin
          stk_we    = 1'b1;
          stk_waddr = avail_q[AW-1:0];
          stk_wdata = EW'(def_rdata_q);
          avail_d   = avail_q + CW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end

    if (ctl_i.flush_finish) begin
      def_cnt_d         = '0;
      res_load          = 1'b1;
      res.granted_index = req_q.index;
      res.status        = ovf_q ? ST_OVERFLOW : ST_OK;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    out_rsp_d = out_rsp_q;
    if (res_load) begin
      out_vld_d = 1'b1;
      out_rsp_d = res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (def_we) begin
      def_mem[def_cnt_q[AW-1:0]] <= in_req_i.index;
    end
    if (def_re) begin
      def_rdata_q <= def_mem[def_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_n_q <= '0;
      avail_q    <= '0;
      clean_q    <= '0;
      def_cnt_q  <= '0;
      ptr_q      <= '0;
      rd_vld_q   <= 1'b0;
      ovf_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      loaded_n_q <= loaded_n_d;
      avail_q    <= avail_d;
      clean_q    <= clean_d;
      def_cnt_q  <= def_cnt_d;
      ptr_q      <= ptr_d;
      rd_vld_q   <= rd_vld_d;
      ovf_q      <= ovf_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q  <= rd_pos_d;
    hit_q     <= hit_d;
    req_q     <= req_d;
    out_rsp_q <= out_rsp_d;
  end

endmodule

// File: rtl/deferred_free_index_allocator.sv
`timescale 1ns / 1ps
// Free, and allocate any on an empty stack: result registered at the accept edge.
// Allocate any: registered read of the stack top, then the result is registered.
// Allocate given: the stack is scanned from the bottom to find the index, then the entries
// above it are compacted; ST_MISSING when absent. One stack read per cycle.
// Flush: deferred entries move onto the stack one entry per cycle through the list port.
// Reset is asynchronous: both stores empty at once, no clearing pass.
// ----------------------------------------------------------------------------
// deferred_free_index_allocator
// Slot-index allocator with a LIFO available stack and a deferred free list.
// ----------------------------------------------------------------------------
module deferred_free_index_allocator
  import dfia_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  ctl_t  ctl;
  stat_t stat;

  dfia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_req_i.command),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  dfia_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
